// ===== src/ocel_pkg.sv =====
`timescale 1ns / 1ps

package ocel_pkg;

  // Default sizes of the list and of a position.
  localparam int DEF_MAX_SLOTS     = 16;
  localparam int DEF_POSITION_BITS = 16;

  // Field widths fixed by the block's interface.
  localparam int AMOUNT_BITS = 16;
  localparam int SUM_BITS    = AMOUNT_BITS + 1;
  localparam int CAP_BITS    = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int PADDR_BITS  = 3;

  // Register map and reset value of the cap.
  localparam logic [PADDR_BITS-1:0] CAP_ADDR  = 3'd0;
  localparam logic [CAP_BITS-1:0]   CAP_RESET = 5'd8;

  // Command codes of an input transaction.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Operation broadcast from the controller to every cell.
  typedef struct packed {
    logic clear;
    logic insert;
    logic hit;
    logic rotate;
  } cell_ctrl_t;

endpackage

// ===== src/ocel_in_if.sv =====
`timescale 1ns / 1ps

interface ocel_in_if
  import ocel_pkg::*;
#(
  parameter int POSITION_BITS = DEF_POSITION_BITS
) ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [POSITION_BITS-1:0] position;
  logic [AMOUNT_BITS-1:0]   amount;

  modport source (output valid, cmd, position, amount, input ready);
  modport sink (input valid, cmd, position, amount, output ready);
endinterface

// ===== src/ocel_out_if.sv =====
`timescale 1ns / 1ps

interface ocel_out_if
  import ocel_pkg::*;
#(
  parameter int POSITION_BITS = DEF_POSITION_BITS
) ();
  logic                     valid;
  logic                     ready;
  logic                     entry_valid;
  logic [POSITION_BITS-1:0] entry_position;
  logic [CAP_BITS-1:0]      entry_amount;
  logic                     last;

  modport source (output valid, entry_valid, entry_position, entry_amount, last, input ready);
  modport sink (input valid, entry_valid, entry_position, entry_amount, last, output ready);
endinterface

// ===== src/ocel_cell.sv =====
`timescale 1ns / 1ps

module ocel_cell
  import ocel_pkg::*;
#(
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic [POSITION_BITS-1:0] new_pos,
  input  logic [SUM_BITS-1:0]      new_amt,
  input  logic                     left_lt,
  input  logic                     left_vld,
  input  logic [POSITION_BITS-1:0] left_pos,
  input  logic [SUM_BITS-1:0]      left_amt,
  input  logic                     right_vld,
  input  logic [POSITION_BITS-1:0] right_pos,
  input  logic [SUM_BITS-1:0]      right_amt,
  output logic                     vld,
  output logic [POSITION_BITS-1:0] pos,
  output logic [SUM_BITS-1:0]      amt,
  output logic                     lt,
  output logic                     eq
);

  // Compare the held entry against the incoming position.
  assign lt = vld && (pos < new_pos);
  assign eq = vld && (pos == new_pos);

  // Valid bit: cleared by reset and by a clear transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctrl.clear) begin
      vld <= 1'b0;
    end else if (ctrl.rotate) begin
      vld <= right_vld;
    end else if (ctrl.insert && !ctrl.hit && !lt) begin
      vld <= left_lt ? 1'b1 : left_vld;
    end
  end

  // Entry payload: merge, insert, shift right on insert, shift left on rotate.
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      pos <= right_pos;
      amt <= right_amt;
    end else if (ctrl.insert) begin
      if (ctrl.hit) begin
        if (eq) begin
          amt <= amt + new_amt;
        end
      end else if (!lt) begin
        if (left_lt) begin
          pos <= new_pos;
          amt <= new_amt;
        end else begin
          pos <= left_pos;
          amt <= left_amt;
        end
      end
    end
  end

endmodule

// ===== src/ordered_capped_extract_list.sv =====
// The first result is registered in the output register on the first rotation step
// (S_ROT) after the accepted transaction. A transaction is one accept followed by
// one rotation step through the cell chain per slot; an output stall holds the
// rotation, and no new transaction is accepted until the rotation ends.
// Reset (synchronous, active high) empties the list and sets the cap to 8.
`timescale 1ns / 1ps

module ordered_capped_extract_list
  import ocel_pkg::*;
#(
  parameter int MAX_SLOTS     = DEF_MAX_SLOTS,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_BITS-1:0]    paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  ocel_in_if.sink                  items,
  ocel_out_if.source               results
);

  localparam int STEP_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(MAX_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ROT  = 2'b10
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [STEP_BITS-1:0]    step;
  logic [CAP_BITS-1:0]     cap;
  logic [CAP_BITS-1:0]     kept;
  logic                    trim_en;

  logic                    accept;
  logic                    advance;
  cell_ctrl_t              ctrl;

  // Chain wiring; the extra slot at the top end is the wrapped entry.
  logic [MAX_SLOTS:0]      vld_w;
  logic [POSITION_BITS-1:0] pos_w [MAX_SLOTS+1];
  logic [SUM_BITS-1:0]     amt_w [MAX_SLOTS+1];
  logic [MAX_SLOTS-1:0]    lt_w;
  logic [MAX_SLOTS-1:0]    eq_w;

  logic [CAP_BITS-1:0]     room;
  logic [SUM_BITS-1:0]     trimmed;
  logic                    keep;
  logic [CAP_BITS-1:0]     kept_next;
  logic                    emit;
  logic                    is_last;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {{(APB_DATA_BITS - CAP_BITS){1'b0}}, cap};

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr == CAP_ADDR)) begin
      cap <= pwdata[CAP_BITS-1:0];
    end
  end

  // Control broadcast: insert (non-zero amount) or clear on acceptance, rotate on each step.
  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign advance     = (state == S_ROT) && (!results.valid || results.ready);

  always_comb begin
    ctrl.clear  = accept && (items.cmd == CMD_CLEAR);
    ctrl.insert = accept && (items.cmd == CMD_ADD) && (items.amount != '0);
    ctrl.hit    = |eq_w;
    ctrl.rotate = advance;
  end

  // Row of cells, each handing entries to its neighbors.
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    logic                     l_lt;
    logic                     l_vld;
    logic [POSITION_BITS-1:0] l_pos;
    logic [SUM_BITS-1:0]      l_amt;

    if (i == 0) begin : g_head
      assign l_lt  = 1'b1;
      assign l_vld = 1'b0;
      assign l_pos = '0;
      assign l_amt = '0;
    end else begin : g_body
      assign l_lt  = lt_w[i-1];
      assign l_vld = vld_w[i-1];
      assign l_pos = pos_w[i-1];
      assign l_amt = amt_w[i-1];
    end

    ocel_cell #(
      .POSITION_BITS(POSITION_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .new_pos  (items.position),
      .new_amt  ({1'b0, items.amount}),
      .left_lt  (l_lt),
      .left_vld (l_vld),
      .left_pos (l_pos),
      .left_amt (l_amt),
      .right_vld(vld_w[i+1]),
      .right_pos(pos_w[i+1]),
      .right_amt(amt_w[i+1]),
      .vld      (vld_w[i]),
      .pos      (pos_w[i]),
      .amt      (amt_w[i]),
      .lt       (lt_w[i]),
      .eq       (eq_w[i])
    );
  end

  // Cap trimming of the head entry as it leaves the chain.
  assign room      = cap - kept;
  assign trimmed   = (amt_w[0] > SUM_BITS'(room)) ? SUM_BITS'(room) : amt_w[0];
  assign keep      = !trim_en || (kept < cap);
  assign kept_next = kept + trimmed[CAP_BITS-1:0];

  assign vld_w[MAX_SLOTS] = vld_w[0] && keep;
  assign pos_w[MAX_SLOTS] = pos_w[0];
  assign amt_w[MAX_SLOTS] = trim_en ? trimmed : amt_w[0];

  assign emit    = (step == '0) || vld_w[MAX_SLOTS];
  assign is_last = !vld_w[MAX_SLOTS] || (step == LAST_STEP) || !vld_w[1] ||
                   (trim_en && (kept_next >= cap));

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        if (advance && (step == LAST_STEP)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      kept    <= '0;
      trim_en <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        step    <= '0;
        kept    <= '0;
        trim_en <= ctrl.insert;
      end else if (advance) begin
        step <= step + 1'b1;
        if (trim_en && vld_w[MAX_SLOTS]) begin
          kept <= kept_next;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance && emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      results.entry_valid    <= vld_w[MAX_SLOTS];
      results.entry_position <= vld_w[MAX_SLOTS] ? pos_w[0] : '0;
      results.entry_amount   <= vld_w[MAX_SLOTS] ? amt_w[MAX_SLOTS][CAP_BITS-1:0] : '0;
      results.last           <= is_last;
    end
  end

  // Checks on the list and the sequencer.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((vld_w[MAX_SLOTS-1:0] & (vld_w[MAX_SLOTS-1:0] + 1'b1)) == '0))
    else $error("list entries do not form a contiguous prefix");

  a_kept: assert property (@(posedge clk) disable iff (rst)
    ((state == S_ROT) && trim_en) |-> (kept <= cap))
    else $error("kept total exceeds the cap");

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((state == S_ROT) && (step == '0)))
    else $error("accepted transaction did not start a rotation");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.entry_valid) |-> results.last)
    else $error("empty-list result not marked last");

endmodule
